FILE: rtl/atpr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atpr_pkg
// Shared widths, the CORDIC step-angle table and sizing constants for the
// accelerometer tilt pipeline.
// ----------------------------------------------------------------------------
package atpr_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int TABLE_LEN         = 24;

    // widths
    localparam int SAMPLE_W = 16;
    localparam int SQ_W     = 32;   // a*a + b*b, unsigned
    localparam int ROOT_IN_W = 64;  // sq << 32
    localparam int ROOT_W   = 32;   // floor sqrt of the above
    localparam int DP_W     = 36;   // cordic x/y datapath
    localparam int ANG_W    = 40;   // nanodegree accumulator
    localparam int ANG_OUT_W = 15;
    localparam int CELL_W   = 5;

    localparam logic signed [ANG_W-1:0] NANO_LIMIT     = 40'sd90000000000;
    localparam logic signed [ANG_W-1:0] NANO_PER_CENTI = 40'sd10000000;
    localparam logic signed [ANG_W-1:0] NANO_HALF_CENTI = 40'sd5000000;

    typedef logic signed [ANG_W-1:0] t_ang;

    function automatic t_ang step_angle(input int idx);
        t_ang v;
        case (idx)
            0:  v = 40'sd45000000000;
            1:  v = 40'sd26565051177;
            2:  v = 40'sd14036243468;
            3:  v = 40'sd7125016349;
            4:  v = 40'sd3576334375;
            5:  v = 40'sd1789910608;
            6:  v = 40'sd895173710;
            7:  v = 40'sd447614171;
            8:  v = 40'sd223810500;
            9:  v = 40'sd111905677;
            10: v = 40'sd55952892;
            11: v = 40'sd27976453;
            12: v = 40'sd13988227;
            13: v = 40'sd6994114;
            14: v = 40'sd3497057;
            15: v = 40'sd1748528;
            16: v = 40'sd874264;
            17: v = 40'sd437132;
            18: v = 40'sd218566;
            19: v = 40'sd109283;
            20: v = 40'sd54642;
            21: v = 40'sd27321;
            22: v = 40'sd13660;
            23: v = 40'sd6830;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/accel_tilt_pitch_roll.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_tilt_pitch_roll
// Pitch and roll from one three-axis accelerometer sample: pipelined exact
// square root of the side magnitude, pipelined CORDIC vectoring for the
// angle, then rounding to centidegrees and truncating to ten-degree cells.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  sample  | in        | i_valid / o_ready    | i_accel_x, i_accel_y, i_accel_z
//  angles  | out       | o_valid / i_ready    | o_pitch_centideg, o_roll_centideg,
//          |           |                      | o_column_cell, o_row_cell
//
// One sample enters per cycle while the output is not stalled; the pipe holds
// 3 + ROOT_W + min(CORDIC_STAGES, 24) + 4 register stages: capture, squares, sums,
// the one-result-bit-per-stage square root, one CORDIC step per stage, then
// saturate, round, quotient and output. The whole pipe advances together and
// freezes while the output register holds an item that is not taken; o_ready
// is high whenever the last stage is empty or being emptied. Reset clears the
// valid bits only.
// ----------------------------------------------------------------------------
module accel_tilt_pitch_roll
    import atpr_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [SAMPLE_W-1:0]  i_accel_x,
    input  logic signed [SAMPLE_W-1:0]  i_accel_y,
    input  logic signed [SAMPLE_W-1:0]  i_accel_z,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [ANG_OUT_W-1:0] o_pitch_centideg,
    output logic signed [ANG_OUT_W-1:0] o_roll_centideg,
    output logic signed [CELL_W-1:0]    o_column_cell,
    output logic signed [CELL_W-1:0]    o_row_cell
);

    localparam int NSTEP = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
    localparam int RS    = ROOT_W;          // root stages
    // pipeline positions
    localparam int P_SQ   = 1;              // squares
    localparam int P_SUM  = 2;              // sums
    localparam int P_RT   = P_SUM + RS;     // root done
    localparam int P_CD   = P_RT + NSTEP;   // cordic done
    localparam int P_SAT  = P_CD + 1;
    localparam int P_RND  = P_SAT + 1;      // offset added
    localparam int P_DIV  = P_RND + 1;      // quotients
    localparam int NPOS   = P_DIV + 1;      // output register
    localparam int L      = NPOS + 1;

    // global advance
    logic w_adv;
    logic [L-1:0] r_vld;
    assign w_adv   = !r_vld[L-1] || i_ready;
    assign o_ready = w_adv;
    assign o_valid = r_vld[L-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[L-2:0], i_valid};
        end
    end

    // ---- stage 0: capture sample ----
    logic signed [SAMPLE_W-1:0] r_x0, r_y0, r_z0;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_x0 <= i_accel_x;
            r_y0 <= i_accel_y;
            r_z0 <= i_accel_z;
        end
    end

    // ---- stage 1: squares ----
    logic [SQ_W-1:0] r_xx, r_yy, r_zz;
    logic signed [SAMPLE_W-1:0] r_x1, r_y1;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_xx <= SQ_W'(r_x0 * r_x0);
            r_yy <= SQ_W'(r_y0 * r_y0);
            r_zz <= SQ_W'(r_z0 * r_z0);
            r_x1 <= r_x0;
            r_y1 <= r_y0;
        end
    end

    // ---- stage 2: sums (lane 0 pitch: y,z; lane 1 roll: x,z) ----
    logic [SQ_W:0] r_sum [2];
    logic signed [SAMPLE_W-1:0] r_op2 [2];
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sum[0] <= {1'b0, r_yy} + {1'b0, r_zz};
            r_sum[1] <= {1'b0, r_xx} + {1'b0, r_zz};
            r_op2[0] <= r_x1;
            r_op2[1] <= r_y1;
        end
    end

    // ---- square root: one result bit per stage, restoring ----
    // value v = sum << 32 (66 bits max 2^63); root bit k from MSB
    localparam int RV_W = 66;
    logic [RV_W-1:0]   r_rem  [2][RS+1];
    logic [ROOT_W-1:0] r_root [2][RS+1];
    logic signed [SAMPLE_W-1:0] r_rop [2][RS+1];

    genvar ln, gs;
    generate
        for (ln = 0; ln < 2; ln++) begin : g_lane
            always_comb begin
                r_rem[ln][0]  = {1'b0, r_sum[ln], 32'd0};
                r_root[ln][0] = '0;
                r_rop[ln][0]  = r_op2[ln];
            end
            for (gs = 0; gs < RS; gs++) begin : g_rt
                localparam int B = RS - 1 - gs;
                logic [RV_W-1:0] w_trial;
                logic [RV_W-1:0] w_sub;
                // trial term (4 * root + 1) at this bit position
                assign w_trial = RV_W'({r_root[ln][gs], 2'b01}) << (2 * B);
                assign w_sub   = r_rem[ln][gs] - w_trial;
                if (gs + 1 <= RS) begin : g_reg
                    always_ff @(posedge i_clk) begin
                        if (w_adv) begin
                            if (r_rem[ln][gs] >= w_trial) begin
                                r_rem[ln][gs+1]  <= w_sub;
                                r_root[ln][gs+1] <= {r_root[ln][gs][ROOT_W-2:0], 1'b1};
                            end else begin
                                r_rem[ln][gs+1]  <= r_rem[ln][gs];
                                r_root[ln][gs+1] <= {r_root[ln][gs][ROOT_W-2:0], 1'b0};
                            end
                            r_rop[ln][gs+1] <= r_rop[ln][gs];
                        end
                    end
                end
            end

            // ---- cordic vectoring, one step per stage ----
            logic signed [DP_W-1:0] r_cx [NSTEP+1];
            logic signed [DP_W-1:0] r_cy [NSTEP+1];
            t_ang                   r_cz [NSTEP+1];
            always_comb begin
                r_cx[0] = DP_W'({1'b0, r_root[ln][RS]});
                r_cy[0] = DP_W'($signed({r_rop[ln][RS], 16'd0}));
                r_cz[0] = '0;
            end
            for (gs = 0; gs < NSTEP; gs++) begin : g_cd
                logic signed [DP_W-1:0] w_dx, w_dy;
                assign w_dx = r_cy[gs] >>> gs;
                assign w_dy = r_cx[gs] >>> gs;
                always_ff @(posedge i_clk) begin
                    if (w_adv) begin
                        if (!r_cy[gs][DP_W-1] && r_cy[gs] != '0) begin
                            r_cx[gs+1] <= r_cx[gs] + w_dx;
                            r_cy[gs+1] <= r_cy[gs] - w_dy;
                            r_cz[gs+1] <= r_cz[gs] + step_angle(gs);
                        end else if (r_cy[gs][DP_W-1]) begin
                            r_cx[gs+1] <= r_cx[gs] - w_dx;
                            r_cy[gs+1] <= r_cy[gs] + w_dy;
                            r_cz[gs+1] <= r_cz[gs] - step_angle(gs);
                        end else begin
                            r_cx[gs+1] <= r_cx[gs];
                            r_cy[gs+1] <= r_cy[gs];
                            r_cz[gs+1] <= r_cz[gs];
                        end
                    end
                end
            end

            // ---- saturate, then magnitude and sign ----
            logic       r_neg_s;
            t_ang       r_mag_s;
            t_ang       w_zc;
            always_comb begin
                w_zc = r_cz[NSTEP];
                if (w_zc > NANO_LIMIT) w_zc = NANO_LIMIT;
                if (w_zc < -NANO_LIMIT) w_zc = -NANO_LIMIT;
            end
            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    r_neg_s <= w_zc[ANG_W-1];
                    r_mag_s <= w_zc[ANG_W-1] ? -w_zc : w_zc;
                end
            end

            // ---- rounding offset; magnitude fits 37 bits ----
            localparam int M_W = 37;
            logic           r_neg_r;
            logic [M_W-1:0] r_rnd, r_trn;
            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    r_neg_r <= r_neg_s;
                    r_rnd   <= M_W'(r_mag_s + NANO_HALF_CENTI);
                    r_trn   <= M_W'(r_mag_s);
                end
            end

            // ---- quotients by constants via reciprocal multiply ----
            // 1e7 = 2^7 * 5^7 and 1e10 = 2^10 * 5^10: drop the power of two,
            // then multiply by ceil(2^s / 5^k) and keep the bits above s
            localparam logic [30:0] RCP_C = 31'd1801439851;   // ceil(2^47 / 78125)
            localparam logic [27:0] RCP_D = 28'd230584301;    // ceil(2^51 / 9765625)
            logic                  r_neg_d;
            logic [13:0]           r_cq;
            logic [3:0]            r_dq;
            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    r_neg_d <= r_neg_r;
                    r_cq    <= 14'((61'(r_rnd[M_W-1:7]) * 61'(RCP_C)) >> 47);
                    r_dq    <= 4'((55'(r_trn[M_W-1:10]) * 55'(RCP_D)) >> 51);
                end
            end

            // ---- output register ----
            logic signed [ANG_OUT_W-1:0] r_centi;
            logic signed [CELL_W-1:0]    r_cell;
            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    r_centi <= r_neg_d ? -$signed({1'b0, r_cq}) : $signed({1'b0, r_cq});
                    r_cell  <= r_neg_d ? -$signed({1'b0, r_dq}) : $signed({1'b0, r_dq});
                end
            end
        end
    endgenerate

    assign o_pitch_centideg = g_lane[0].r_centi;
    assign o_roll_centideg  = g_lane[1].r_centi;
    assign o_row_cell       = g_lane[0].r_cell;
    assign o_column_cell    = g_lane[1].r_cell;

endmodule

FILE: rtl/atpr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atpr_checker
// Port-level checks on the tilt block's outputs and handshake.
// ----------------------------------------------------------------------------
module atpr_checker
    import atpr_pkg::*;
(
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_ready,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic signed [ANG_OUT_W-1:0] o_pitch_centideg,
    input logic signed [ANG_OUT_W-1:0] o_roll_centideg,
    input logic signed [CELL_W-1:0]    o_column_cell,
    input logic signed [CELL_W-1:0]    o_row_cell
);

    // output valid and pitch angle hold while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_pitch_centideg))
        else $error("output item changed while stalled");

    // ready follows the output stall
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |-> !o_ready)
        else $error("input taken during stall");

    // angles in range
    a_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_pitch_centideg <= 9000 && o_pitch_centideg >= -9000
                 && o_roll_centideg <= 9000 && o_roll_centideg >= -9000)
        else $error("angle out of range");

    // cells in range
    a_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_row_cell <= 9 && o_row_cell >= -9
                 && o_column_cell <= 9 && o_column_cell >= -9)
        else $error("cell out of range");

endmodule

bind accel_tilt_pitch_roll atpr_checker u_atpr_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_pitch_centideg(o_pitch_centideg),
    .o_roll_centideg(o_roll_centideg), .o_column_cell(o_column_cell),
    .o_row_cell(o_row_cell)
);
